/* sv/bbp_pkg.sv */
// Shared types and constants for the bicubic Bezier patch evaluator.
package bbp_pkg;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_U = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_V = 2'd1;

   localparam int DIV_W   = 8;
   localparam int GRID_W  = 8;
   localparam int COORD_W = 32;
   localparam int SLOT_W  = 4;
   localparam int SLOTS   = 16;
   localparam logic [DIV_W-1:0] DIV_RESET = 8'd8;

   typedef struct packed {
      op_type                      op;
      logic [SLOT_W-1:0]           slot;
      logic signed [COORD_W-1:0]   x;
      logic signed [COORD_W-1:0]   y;
      logic signed [COORD_W-1:0]   z;
   } item_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_PUSH
   } fr_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CALC,
      BK_EMIT
   } bk_state_type;

endpackage

/* sv/bbp_front.sv */
// Front end: accepts requests, holds the division registers, forms t and s by serial division.
module bbp_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bbp_pkg::item_type               req_item,
   input  logic [bbp_pkg::GRID_W-1:0]      grid_u,
   input  logic [bbp_pkg::GRID_W-1:0]      grid_v,
   input  logic                            csr_we,
   input  logic [bbp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bbp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            push,
   input  logic                            full,
   output bbp_pkg::item_type               push_item,
   output logic [FRAC_BITS:0]              push_t,
   output logic [FRAC_BITS:0]              push_s
);
   import bbp_pkg::*;

   localparam int WW    = FRAC_BITS + 1;
   localparam int NW    = FRAC_BITS + GRID_W + 1;
   localparam int CNT_W = $clog2(NW + 1);
   localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

   fr_state_type state_ff, state_in;
   logic [DIV_W-1:0] div_u_ff, div_v_ff;
   logic [DIV_W-1:0] d_u_ff, d_v_ff;
   logic [DIV_W-1:0] d_u_in, d_v_in;
   logic [DIV_W-1:0] rem_u_ff, rem_v_ff;
   logic [NW-1:0]    num_u_ff, num_v_ff;
   logic [NW-1:0]    num_u_in, num_v_in;
   logic [DIV_W-1:0] rem_u_nx, rem_v_nx;
   logic [NW-1:0]    num_u_nx, num_v_nx;
   logic             over_u_ff, over_v_ff;
   logic [CNT_W-1:0] cnt_ff;
   item_type         item_ff;
   logic             accept, div_done;

   function automatic logic [DIV_W+NW-1:0] div_step(input logic [DIV_W-1:0] rem,
                                                    input logic [NW-1:0] num,
                                                    input logic [DIV_W-1:0] d);
      logic [DIV_W:0]   sh;
      logic [DIV_W-1:0] r;
      logic             b;
      sh = {rem, num[NW-1]};
      if (sh >= {1'b0, d}) begin
         r = DIV_W'(sh - {1'b0, d});
         b = 1'b1;
      end else begin
         r = sh[DIV_W-1:0];
         b = 1'b0;
      end
      return {r, num[NW-2:0], b};
   endfunction

   // a divisions register of zero acts as one
   assign d_u_in   = (div_u_ff == '0) ? DIV_W'(1) : div_u_ff;
   assign d_v_in   = (div_v_ff == '0) ? DIV_W'(1) : div_v_ff;
   assign num_u_in = {grid_u, FRAC_BITS'(d_u_in >> 1), 1'b0} >> 1;
   assign num_v_in = {grid_v, FRAC_BITS'(d_v_in >> 1), 1'b0} >> 1;
   assign {rem_u_nx, num_u_nx} = div_step(rem_u_ff, num_u_ff, d_u_ff);
   assign {rem_v_nx, num_v_nx} = div_step(rem_v_ff, num_v_ff, d_v_ff);
   assign div_done = (cnt_ff == CNT_W'(NW - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (req_valid) begin
               state_in = (req_item.op == OP_EVAL) ? FR_DIV : FR_PUSH;
            end
         end
         FR_DIV: begin
            if (div_done) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            if (!full) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != FR_IDLE);
      accept    = (state_ff == FR_IDLE) && req_valid;
      push      = (state_ff == FR_PUSH) && !full;
      push_item = item_ff;
      push_t    = over_u_ff ? ONE : num_u_ff[WW-1:0];
      push_s    = over_v_ff ? ONE : num_v_ff[WW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         div_u_ff <= DIV_RESET;
         div_v_ff <= DIV_RESET;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == CSR_DIV_U) begin
            div_u_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_DIV_V) begin
            div_v_ff <= csr_wdata;
         end
         if (accept) begin
            cnt_ff <= '0;
         end else if (state_ff == FR_DIV) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff   <= req_item;
         d_u_ff    <= d_u_in;
         d_v_ff    <= d_v_in;
         over_u_ff <= (grid_u >= d_u_in);
         over_v_ff <= (grid_v >= d_v_in);
         rem_u_ff  <= '0;
         rem_v_ff  <= '0;
         num_u_ff  <= num_u_in;
         num_v_ff  <= num_v_in;
      end else if (state_ff == FR_DIV) begin
         rem_u_ff <= rem_u_nx;
         rem_v_ff <= rem_v_nx;
         num_u_ff <= num_u_nx;
         num_v_ff <= num_v_nx;
      end
   end

endmodule

/* sv/bbp_fifo.sv */
// Two-entry queue between the front end and the evaluation sequencer.
module bbp_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* sv/bbp_back.sv */
// Back end: control point store, Bernstein weights on a shared multiplier, weighted sum.
module bbp_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              empty,
   output logic                              pop,
   input  bbp_pkg::item_type                 pop_item,
   input  logic [FRAC_BITS:0]                pop_t,
   input  logic [FRAC_BITS:0]                pop_s,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bbp_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [bbp_pkg::COORD_W-1:0] rsp_point_y,
   output logic signed [bbp_pkg::COORD_W-1:0] rsp_point_z
);
   import bbp_pkg::*;

   localparam int WW    = FRAC_BITS + 1;
   localparam int AW    = WW + 2;
   localparam int PW    = AW + WW;
   localparam int CW    = COORD_W + WW + 1;
   localparam int ACC_W = CW + 4;
   localparam logic [WW-1:0] ONE  = WW'(1) << FRAC_BITS;
   localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-COORD_W){1'b0}}, 32'h7FFF_FFFF};
   localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-COORD_W){1'b1}}, 32'h8000_0000};
   // step plan: 0..11 weights, 12..27 pair products, then W, control product, accumulate
   localparam logic [4:0] ST_PAIR = 5'd12;
   localparam logic [4:0] ST_WREG = 5'd13;
   localparam logic [4:0] ST_CMUL = 5'd14;
   localparam logic [4:0] ST_ACC  = 5'd15;
   localparam logic [4:0] ST_WEND = 5'd28;
   localparam logic [4:0] ST_CEND = 5'd29;
   localparam logic [4:0] ST_LAST = 5'd30;

   bk_state_type state_ff, state_in;
   logic [4:0]    step_ff;
   logic [4:0]    pair_j, prev_j, cmul_j;
   logic [WW-1:0] t_ff, s_ff, ti, si;
   logic [WW-1:0] tt_t_ff, qq_t_ff, tt_s_ff, qq_s_ff;
   logic [WW-1:0] wt_ff [4];
   logic [WW-1:0] ws_ff [4];
   logic [AW-1:0] mul_a;
   logic [WW-1:0] mul_b;
   logic [PW-1:0] prod_ff, prod_rnd;
   logic [WW-1:0] rnd_val;
   logic [WW-1:0] w_ff;
   logic signed [COORD_W-1:0] ctrl_x_ff [SLOTS];
   logic signed [COORD_W-1:0] ctrl_y_ff [SLOTS];
   logic signed [COORD_W-1:0] ctrl_z_ff [SLOTS];
   logic signed [CW-1:0]    cx_ff, cy_ff, cz_ff;
   logic signed [ACC_W-1:0] ax_ff, ay_ff, az_ff;
   logic rsp_valid_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic start_eval, store_we, emit;

   function automatic logic [AW-1:0] triple(input logic [AW-1:0] x);
      return x + (x << 1);
   endfunction

   function automatic logic signed [COORD_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] q;
      q = (acc + HALF_ACC) >>> FRAC_BITS;
      if (q > SAT_MAX) begin
         return SAT_MAX[COORD_W-1:0];
      end else if (q < SAT_MIN) begin
         return SAT_MIN[COORD_W-1:0];
      end
      return q[COORD_W-1:0];
   endfunction

   assign ti       = ONE - t_ff;
   assign si       = ONE - s_ff;
   assign pair_j   = step_ff - ST_PAIR;
   assign prev_j   = step_ff - 5'd1;
   assign cmul_j   = step_ff - ST_CMUL;
   assign prod_rnd = (prod_ff + HALF) >> FRAC_BITS;
   assign rnd_val  = prod_rnd[WW-1:0];

   always_comb begin
      case (step_ff)
         5'd0:  begin mul_a = AW'(t_ff);            mul_b = t_ff;    end
         5'd1:  begin mul_a = AW'(ti);              mul_b = ti;      end
         5'd2:  begin mul_a = AW'(s_ff);            mul_b = s_ff;    end
         5'd3:  begin mul_a = AW'(si);              mul_b = si;      end
         5'd4:  begin mul_a = AW'(qq_t_ff);         mul_b = ti;      end
         5'd5:  begin mul_a = triple(AW'(t_ff));    mul_b = qq_t_ff; end
         5'd6:  begin mul_a = triple(AW'(tt_t_ff)); mul_b = ti;      end
         5'd7:  begin mul_a = AW'(tt_t_ff);         mul_b = t_ff;    end
         5'd8:  begin mul_a = AW'(qq_s_ff);         mul_b = si;      end
         5'd9:  begin mul_a = triple(AW'(s_ff));    mul_b = qq_s_ff; end
         5'd10: begin mul_a = triple(AW'(tt_s_ff)); mul_b = si;      end
         5'd11: begin mul_a = AW'(tt_s_ff);         mul_b = s_ff;    end
         default: begin
            mul_a = AW'(wt_ff[pair_j[3:2]]);
            mul_b = ws_ff[pair_j[1:0]];
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!empty && pop_item.op == OP_EVAL) begin
               state_in = BK_CALC;
            end
         end
         BK_CALC: begin
            if (step_ff == ST_LAST) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop        = (state_ff == BK_IDLE) && !empty;
      store_we   = pop && (pop_item.op == OP_LOAD);
      start_eval = pop && (pop_item.op == OP_EVAL);
      emit       = (state_ff == BK_EMIT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            ctrl_x_ff[i] <= '0;
            ctrl_y_ff[i] <= '0;
            ctrl_z_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (start_eval) begin
            step_ff <= '0;
         end else if (state_ff == BK_CALC) begin
            step_ff <= step_ff + 5'd1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (store_we) begin
            ctrl_x_ff[pop_item.slot] <= pop_item.x;
            ctrl_y_ff[pop_item.slot] <= pop_item.y;
            ctrl_z_ff[pop_item.slot] <= pop_item.z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_eval) begin
         t_ff  <= pop_t;
         s_ff  <= pop_s;
         ax_ff <= '0;
         ay_ff <= '0;
         az_ff <= '0;
      end
      if (state_ff == BK_CALC) begin
         prod_ff <= mul_a * mul_b;
         // retire the product issued at the previous step
         if (step_ff >= 5'd1 && step_ff <= ST_PAIR) begin
            case (prev_j)
               5'd0:  tt_t_ff  <= rnd_val;
               5'd1:  qq_t_ff  <= rnd_val;
               5'd2:  tt_s_ff  <= rnd_val;
               5'd3:  qq_s_ff  <= rnd_val;
               5'd4:  wt_ff[0] <= rnd_val;
               5'd5:  wt_ff[1] <= rnd_val;
               5'd6:  wt_ff[2] <= rnd_val;
               5'd7:  wt_ff[3] <= rnd_val;
               5'd8:  ws_ff[0] <= rnd_val;
               5'd9:  ws_ff[1] <= rnd_val;
               5'd10: ws_ff[2] <= rnd_val;
               5'd11: ws_ff[3] <= rnd_val;
               default: ;
            endcase
         end
         if (step_ff >= ST_WREG && step_ff <= ST_WEND) begin
            w_ff <= rnd_val;
         end
         if (step_ff >= ST_CMUL && step_ff <= ST_CEND) begin
            cx_ff <= $signed({1'b0, w_ff}) * ctrl_x_ff[cmul_j[3:0]];
            cy_ff <= $signed({1'b0, w_ff}) * ctrl_y_ff[cmul_j[3:0]];
            cz_ff <= $signed({1'b0, w_ff}) * ctrl_z_ff[cmul_j[3:0]];
         end
         if (step_ff >= ST_ACC && step_ff <= ST_LAST) begin
            ax_ff <= ax_ff + ACC_W'(cx_ff);
            ay_ff <= ay_ff + ACC_W'(cy_ff);
            az_ff <= az_ff + ACC_W'(cz_ff);
         end
      end
      if (emit) begin
         px_ff <= finish(ax_ff);
         py_ff <= finish(ay_ff);
         pz_ff <= finish(az_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = px_ff;
   assign rsp_point_y = py_ff;
   assign rsp_point_z = pz_ff;

endmodule

/* sv/bicubic_bezier_patch_eval.sv */
// Bicubic Bezier patch evaluator: load control points, evaluate surface points on a grid.
//
// A load request writes one of the sixteen control points and gives no response; an
// evaluate request gives one surface point, rounded and saturated to signed Q16.16.
// The front end takes a request and forms t and s by a bit-serial divide, and it stalls
// further requests until it has pushed the current one. It hands each request through
// a two-entry queue to the back end. The back end runs each evaluate as a 31-step
// sequence on one shared weight multiplier plus three coordinate multipliers and takes
// no new request from the queue until that point has gone to the output register. Loads
// are applied in request order. A finished point waits in the output register while the
// next request is already being worked on.
module bicubic_bezier_patch_eval #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [bbp_pkg::SLOT_W-1:0]         req_point_index,
   input  logic signed [bbp_pkg::COORD_W-1:0] req_ctrl_x,
   input  logic signed [bbp_pkg::COORD_W-1:0] req_ctrl_y,
   input  logic signed [bbp_pkg::COORD_W-1:0] req_ctrl_z,
   input  logic [bbp_pkg::GRID_W-1:0]         req_grid_u,
   input  logic [bbp_pkg::GRID_W-1:0]         req_grid_v,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [bbp_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [bbp_pkg::COORD_W-1:0] rsp_point_y,
   output logic signed [bbp_pkg::COORD_W-1:0] rsp_point_z,
   input  logic                               csr_we,
   input  logic [bbp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bbp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bbp_pkg::*;

   localparam int WW = FRAC_BITS + 1;
   localparam int QW = $bits(item_type) + 2 * WW;

   item_type      req_item, f_item, b_item;
   logic [WW-1:0] f_t, f_s, b_t, b_s;
   logic          push, full, pop, empty;
   logic [QW-1:0] q_out;

   always_comb begin
      req_item.op   = op_type'(req_op);
      req_item.slot = req_point_index;
      req_item.x    = req_ctrl_x;
      req_item.y    = req_ctrl_y;
      req_item.z    = req_ctrl_z;
   end

   assign {b_item, b_t, b_s} = q_out;

   bbp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .grid_u    (req_grid_u),
      .grid_v    (req_grid_v),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push),
      .full      (full),
      .push_item (f_item),
      .push_t    (f_t),
      .push_s    (f_s)
   );

   bbp_fifo #(.WIDTH(QW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_item, f_t, f_s}),
      .full      (full),
      .pop       (pop),
      .pop_data  (q_out),
      .empty     (empty)
   );

   bbp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (empty),
      .pop         (pop),
      .pop_item    (b_item),
      .pop_t       (b_t),
      .pop_s       (b_s),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .rsp_point_z (rsp_point_z)
   );

endmodule

/* sv/bbp_checker.sv */
// Port-level checks for the patch evaluator, bound to the top level.
module bbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_op,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_point_x
);
   logic [3:0] pending_ff;
   logic       eval_acc, rsp_acc;

   assign eval_acc = req_valid && !req_stall && req_op;
   assign rsp_acc  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + {3'b0, eval_acc} - {3'b0, rsp_acc};
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x))
      else $error("stalled response dropped or changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response without an outstanding evaluate request");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      eval_acc && pending_ff == 4'd0 |=> !rsp_valid)
      else $error("response appeared too early");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind bicubic_bezier_patch_eval bbp_checker u_bbp_checker (.*);

/* test/testbench.sv */
// Self-checking testbench for the bicubic Bezier patch evaluator.
`timescale 1ns / 1ps

class patch_scoreboard;
   logic signed [31:0] ctl_x [16];
   logic signed [31:0] ctl_y [16];
   logic signed [31:0] ctl_z [16];
   logic [7:0] div_u;
   logic [7:0] div_v;
   logic signed [31:0] pending_x [$];
   logic signed [31:0] pending_y [$];
   logic signed [31:0] pending_z [$];
   int errors;

   function new();
      div_u = 8;
      div_v = 8;
      errors = 0;
      for (int i = 0; i < 16; i++) begin
         ctl_x[i] = 0;
         ctl_y[i] = 0;
         ctl_z[i] = 0;
      end
   endfunction

   function longint unsigned round_frac(longint unsigned p);
      return (p + 64'd32768) >> 16;
   endfunction

   function longint unsigned grid_param(logic [7:0] idx, logic [7:0] dv);
      longint unsigned d;
      d = (dv == 0) ? 1 : dv;
      if (idx >= d) return 64'd65536;
      return ((longint'(idx) << 16) + d / 2) / d;
   endfunction

   function void bernstein(longint unsigned t, output longint unsigned w [4]);
      longint unsigned ti, tt, qq;
      ti = 64'd65536 - t;
      tt = round_frac(t * t);
      qq = round_frac(ti * ti);
      w[0] = round_frac(qq * ti);
      w[1] = round_frac(3 * t * qq);
      w[2] = round_frac(3 * tt * ti);
      w[3] = round_frac(tt * t);
   endfunction

   function logic signed [31:0] settle(longint sum);
      longint r, q;
      r = sum + 32768;
      q = r >>> 16;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   function void set_divisions(bit which_v, logic [7:0] value);
      if (which_v) div_v = value;
      else div_u = value;
   endfunction

   function void note_request(bit op, logic [3:0] slot, logic signed [31:0] x,
                              logic signed [31:0] y, logic signed [31:0] z,
                              logic [7:0] u, logic [7:0] v);
      longint unsigned wt [4], ws [4];
      longint w, sx, sy, sz;
      if (op == bbp_pkg::OP_LOAD) begin
         ctl_x[slot] = x;
         ctl_y[slot] = y;
         ctl_z[slot] = z;
         return;
      end
      bernstein(grid_param(u, div_u), wt);
      bernstein(grid_param(v, div_v), ws);
      sx = 0; sy = 0; sz = 0;
      for (int k = 0; k < 4; k++)
         for (int l = 0; l < 4; l++) begin
            w = round_frac(wt[k] * ws[l]);
            sx += w * longint'(ctl_x[k*4+l]);
            sy += w * longint'(ctl_y[k*4+l]);
            sz += w * longint'(ctl_z[k*4+l]);
         end
      pending_x.push_back(settle(sx));
      pending_y.push_back(settle(sy));
      pending_z.push_back(settle(sz));
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_point(logic signed [31:0] x, logic signed [31:0] y,
                    logic signed [31:0] z);
      if (pending_x.size() == 0) begin
         report($sformatf("unexpected point %h %h %h", x, y, z));
         return;
      end
      if (x !== pending_x[0]) report($sformatf("x got %h want %h", x, pending_x[0]));
      if (y !== pending_y[0]) report($sformatf("y got %h want %h", y, pending_y[0]));
      if (z !== pending_z[0]) report($sformatf("z got %h want %h", z, pending_z[0]));
      void'(pending_x.pop_front());
      void'(pending_y.pop_front());
      void'(pending_z.pop_front());
   endtask
endclass

module testbench;
   import bbp_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_op;
   logic [SLOT_W-1:0] req_point_index;
   logic signed [COORD_W-1:0] req_ctrl_x, req_ctrl_y, req_ctrl_z;
   logic [GRID_W-1:0] req_grid_u, req_grid_v;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [COORD_W-1:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   patch_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   longint cycles;

   bicubic_bezier_patch_eval dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 1200000) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver: sample at rising edge, redraw stall at falling edge
   initial begin
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_point(rsp_point_x, rsp_point_y, rsp_point_z);
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   function logic signed [31:0] coord_value();
      case ($urandom_range(7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 0;
         3: return $signed($urandom_range(65536 * 8)) - 32'sd262144;
         default: return $urandom;
      endcase
   endfunction

   task send_request(bit op, logic [3:0] slot, logic signed [31:0] x,
                     logic signed [31:0] y, logic signed [31:0] z,
                     logic [7:0] u, logic [7:0] v);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1;
      req_op = op;
      req_point_index = slot;
      req_ctrl_x = x;
      req_ctrl_y = y;
      req_ctrl_z = z;
      req_grid_u = u;
      req_grid_v = v;
      do @(posedge clock); while (req_stall);
      board.note_request(op, slot, x, y, z, u, v);
      @(negedge clock);
      req_valid = 0;
   endtask

   task load_point(logic [3:0] slot, logic signed [31:0] x, logic signed [31:0] y,
                   logic signed [31:0] z);
      send_request(OP_LOAD, slot, x, y, z, 8'($urandom), 8'($urandom));
   endtask

   task eval_point(logic [7:0] u, logic [7:0] v);
      send_request(OP_EVAL, 4'($urandom), $urandom, $urandom, $urandom, u, v);
   endtask

   task drain();
      while (board.pending_x.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [7:0] value);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 0;
      if (idx == CSR_DIV_U) board.set_divisions(0, value);
      else if (idx == CSR_DIV_V) board.set_divisions(1, value);
   endtask

   task random_phase(int count);
      logic [7:0] du, dv;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            load_point(4'($urandom), coord_value(), coord_value(), coord_value());
         else begin
            du = board.div_u; dv = board.div_v;
            eval_point(8'($urandom_range(2) == 0 ? $urandom : $urandom_range(du)),
                       8'($urandom_range(2) == 0 ? $urandom : $urandom_range(dv)));
         end
      end
   endtask

   initial begin
      board = new();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1;
      req_valid = 0;
      req_op = OP_LOAD;
      req_point_index = 0;
      req_ctrl_x = 0; req_ctrl_y = 0; req_ctrl_z = 0;
      req_grid_u = 0; req_grid_v = 0;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // evaluate before any load gives zero
      eval_point(0, 0);
      eval_point(4, 8);
      for (int i = 0; i < 16; i++)
         load_point(4'(i), (i % 3 == 0) ? 32'sh7fffffff : 32'sh80000000,
                    i << 16, -(i << 16));
      eval_point(0, 0);
      eval_point(8, 8);
      eval_point(255, 255);
      eval_point(3, 200);
      drain();
      // invalid index ignored, then zero divisions act as one
      write_csr(2'd3, 8'd5);
      write_csr(CSR_DIV_U, 0);
      write_csr(CSR_DIV_V, 255);
      eval_point(0, 127);
      eval_point(1, 254);
      eval_point(9, 255);
      drain();

      send_idle_pct = 35; recv_idle_pct = 76;
      write_csr(CSR_DIV_U, 255);
      write_csr(CSR_DIV_V, 1);
      random_phase(300);
      drain();
      write_csr(CSR_DIV_U, 1);
      write_csr(CSR_DIV_V, 0);
      random_phase(300);
      drain();

      send_idle_pct = 76; recv_idle_pct = 35;
      write_csr(CSR_DIV_U, 8'($urandom_range(1, 255)));
      write_csr(CSR_DIV_V, 8'($urandom_range(1, 255)));
      random_phase(300);
      drain();
      write_csr(CSR_DIV_U, 8);
      write_csr(CSR_DIV_V, 8);
      random_phase(300);
      drain();

      send_idle_pct = 0; recv_idle_pct = 0;
      write_csr(CSR_DIV_U, 8'($urandom_range(1, 255)));
      write_csr(CSR_DIV_V, 8'($urandom_range(1, 255)));
      random_phase(300);
      drain();
      write_csr(CSR_DIV_U, 3);
      write_csr(CSR_DIV_V, 17);
      random_phase(280);
      drain();

      if (board.errors == 0 && board.pending_x.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
